// ===== rtl/jbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the blockiness statistics block.
// No dependencies.
package jbs_pkg;

	localparam int CFG_W = 13;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd1024;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd768;
	localparam logic [CFG_W-1:0] MIN_SIZE = 13'd2;
	localparam logic [CFG_W-1:0] MAX_HEIGHT = 13'd4096;
	localparam int ROW_W = 12;

	localparam int PIX_W = 8;
	localparam int DIFF_W = 9;

	localparam int BSUM_W = 29;
	localparam int ASUM_W = 32;
	localparam int ZCNT_W = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// one classified pixel as handed from front to back
	typedef struct packed {
		logic [PIX_W-1:0] h_abs;
		logic [PIX_W-1:0] v_abs;
		logic             h_bnd;
		logic             v_bnd;
		logic             h_cross;
		logic             v_cross;
		logic             last;
	} jbs_item_t;

	typedef struct packed {
		logic              valid;
		logic [QCNT_W-1:0] count;
	} jbs_qstat_t;

endpackage

// ===== rtl/jbs_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module jbs_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/jbs_front.sv =====
`timescale 1ns / 1ps
// Front end: config registers, raster position, row buffer and neighbour
// differences. Emits one classified word per pixel. Uses jbs_pkg, jbs_ram.
module jbs_front
	import jbs_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	parameter int BLOCK_SIZE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	input  jbs_qstat_t           qstat,
	output logic                 push,
	output jbs_item_t            push_item
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int SZ_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int PH_W = $clog2(BLOCK_SIZE);
	localparam logic [SZ_W-1:0] MAX_W = SZ_W'(MAX_WIDTH);
	localparam logic [PH_W-1:0] PH_LAST = PH_W'(BLOCK_SIZE - 1);

	logic [CFG_W-1:0] width_q, height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PH_W-1:0]  cph_q, rph_q;
	logic [SZ_W-1:0]  w_raw, w_eff;
	logic [CFG_W-1:0] h_eff;
	logic             last_col, last_row, accept;

	// s1 stage
	logic              vld_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [COL_W-1:0]  addr_s1;
	logic              h_on_s1, h_x_s1, h_b_s1, v_on_s1, v_x_s1, v_b_s1, last_s1;

	logic [PIX_W-1:0]  left_pix_q;
	logic [DIFF_W-1:0] left_diff_q;
	logic [PIX_W+DIFF_W-1:0] above;
	logic [PIX_W-1:0]  above_pix;
	logic [DIFF_W-1:0] above_diff;
	logic [DIFF_W-1:0] dh, dv, dv_st, dh_st, dh_abs, dv_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: width_q <= cfg_wdata;
				REG_FRAME_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign w_raw = SZ_W'(width_q);

	always_comb begin
		if (width_q < MIN_SIZE) w_eff = SZ_W'(MIN_SIZE);
		else if (w_raw > MAX_W) w_eff = MAX_W;
		else w_eff = w_raw;
		if (height_q < MIN_SIZE) h_eff = MIN_SIZE;
		else if (height_q > MAX_HEIGHT) h_eff = MAX_HEIGHT;
		else h_eff = height_q;
	end

	assign last_col = (SZ_W'(col_q) + SZ_W'(1)) >= w_eff;
	assign last_row = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;

	// one s1 word may still be on its way into the queue
	assign in_ready = ((QCNT_W + 1)'(qstat.count) + (QCNT_W + 1)'(vld_s1))
		< (QCNT_W + 1)'(QUEUE_DEPTH);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cph_q <= '0;
			rph_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				cph_q <= '0;
				if (last_row) begin
					row_q <= '0;
					rph_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					rph_q <= (rph_q == PH_LAST) ? '0 : rph_q + PH_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				cph_q <= (cph_q == PH_LAST) ? '0 : cph_q + PH_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel;
			addr_s1 <= col_q;
			h_on_s1 <= col_q != '0;
			h_x_s1 <= col_q > COL_W'(1);
			h_b_s1 <= (col_q != '0) && (cph_q == '0);
			v_on_s1 <= row_q != '0;
			v_x_s1 <= row_q > ROW_W'(1);
			v_b_s1 <= (row_q != '0) && (rph_q == '0);
			last_s1 <= last_col && last_row;
		end
	end

	// row above: pixel and vertical difference per column
	jbs_ram #(
		.WIDTH(PIX_W + DIFF_W),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk    (clk),
		.wr_en  (vld_s1),
		.wr_addr(addr_s1),
		.wr_data({pix_s1, dv_st}),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(above)
	);

	assign above_pix = above[PIX_W+DIFF_W-1:DIFF_W];
	assign above_diff = above[DIFF_W-1:0];

	assign dh = {1'b0, pix_s1} - {1'b0, left_pix_q};
	assign dv = {1'b0, pix_s1} - {1'b0, above_pix};
	assign dh_st = h_on_s1 ? dh : '0;
	assign dv_st = v_on_s1 ? dv : '0;
	assign dh_abs = dh[DIFF_W-1] ? -dh : dh;
	assign dv_abs = dv[DIFF_W-1] ? -dv : dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pix_q <= '0;
			left_diff_q <= '0;
		end else if (vld_s1) begin
			left_pix_q <= pix_s1;
			left_diff_q <= dh_st;
		end
	end

	// strictly opposite signs; zero never crosses
	function automatic logic opposite(input logic [DIFF_W-1:0] a, input logic [DIFF_W-1:0] b);
		logic a_neg, a_pos, b_neg, b_pos;
		a_neg = a[DIFF_W-1];
		b_neg = b[DIFF_W-1];
		a_pos = !a[DIFF_W-1] && (a != '0);
		b_pos = !b[DIFF_W-1] && (b != '0);
		return (a_neg && b_pos) || (a_pos && b_neg);
	endfunction

	assign push = vld_s1;

	always_comb begin
		push_item.h_abs = h_on_s1 ? dh_abs[PIX_W-1:0] : '0;
		push_item.v_abs = v_on_s1 ? dv_abs[PIX_W-1:0] : '0;
		push_item.h_bnd = h_b_s1;
		push_item.v_bnd = v_b_s1;
		push_item.h_cross = h_x_s1 && opposite(left_diff_q, dh);
		push_item.v_cross = v_x_s1 && opposite(above_diff, dv);
		push_item.last = last_s1;
	end

endmodule

// ===== rtl/jbs_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified words between front and back.
// Uses jbs_pkg.
module jbs_queue
	import jbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  jbs_item_t  push_item,
	input  logic       pop,
	output jbs_qstat_t qstat,
	output jbs_item_t  head
);

	jbs_item_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			unique case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	assign qstat.valid = count_q != '0;
	assign qstat.count = count_q;
	assign head = mem_q[rd_ptr_q];

endmodule

// ===== rtl/jbs_back.sv =====
`timescale 1ns / 1ps
// Back end: saturating accumulators and the result register.
// Uses jbs_pkg.
module jbs_back
	import jbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  jbs_qstat_t        qstat,
	input  jbs_item_t         head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BSUM_W-1:0] h_boundary_sum,
	output logic [BSUM_W-1:0] v_boundary_sum,
	output logic [ASUM_W-1:0] h_activity_sum,
	output logic [ASUM_W-1:0] v_activity_sum,
	output logic [ZCNT_W-1:0] h_crossing_count,
	output logic [ZCNT_W-1:0] v_crossing_count
);

	logic [BSUM_W-1:0] bh_q, bv_q, bh_nx, bv_nx;
	logic [ASUM_W-1:0] ah_q, av_q, ah_nx, av_nx;
	logic [ZCNT_W-1:0] zh_q, zv_q, zh_nx, zv_nx;
	logic [BSUM_W:0]   bh_sum, bv_sum;
	logic [ASUM_W:0]   ah_sum, av_sum;
	logic [ZCNT_W:0]   zh_sum, zv_sum;
	logic              out_valid_q, load;

	assign bh_sum = {1'b0, bh_q} + (BSUM_W + 1)'(head.h_bnd ? head.h_abs : '0);
	assign bv_sum = {1'b0, bv_q} + (BSUM_W + 1)'(head.v_bnd ? head.v_abs : '0);
	assign ah_sum = {1'b0, ah_q} + (ASUM_W + 1)'(head.h_abs);
	assign av_sum = {1'b0, av_q} + (ASUM_W + 1)'(head.v_abs);
	assign zh_sum = {1'b0, zh_q} + (ZCNT_W + 1)'(head.h_cross);
	assign zv_sum = {1'b0, zv_q} + (ZCNT_W + 1)'(head.v_cross);

	// saturate at the top of each field
	assign bh_nx = bh_sum[BSUM_W] ? '1 : bh_sum[BSUM_W-1:0];
	assign bv_nx = bv_sum[BSUM_W] ? '1 : bv_sum[BSUM_W-1:0];
	assign ah_nx = ah_sum[ASUM_W] ? '1 : ah_sum[ASUM_W-1:0];
	assign av_nx = av_sum[ASUM_W] ? '1 : av_sum[ASUM_W-1:0];
	assign zh_nx = zh_sum[ZCNT_W] ? '1 : zh_sum[ZCNT_W-1:0];
	assign zv_nx = zv_sum[ZCNT_W] ? '1 : zv_sum[ZCNT_W-1:0];

	// a frame-end word waits only while the result register is full and out_ready is low
	assign pop = qstat.valid && (!head.last || !out_valid_q || out_ready);
	assign load = pop && head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bh_q <= '0;
			bv_q <= '0;
			ah_q <= '0;
			av_q <= '0;
			zh_q <= '0;
			zv_q <= '0;
		end else if (pop) begin
			if (head.last) begin
				bh_q <= '0;
				bv_q <= '0;
				ah_q <= '0;
				av_q <= '0;
				zh_q <= '0;
				zv_q <= '0;
			end else begin
				bh_q <= bh_nx;
				bv_q <= bv_nx;
				ah_q <= ah_nx;
				av_q <= av_nx;
				zh_q <= zh_nx;
				zv_q <= zv_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			h_boundary_sum <= bh_nx;
			v_boundary_sum <= bv_nx;
			h_activity_sum <= ah_nx;
			v_activity_sum <= av_nx;
			h_crossing_count <= zh_nx;
			v_crossing_count <= zv_nx;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/jpeg_blockiness_statistics_top.sv =====
`timescale 1ns / 1ps
// Blockiness, activity and zero-crossing statistics of grey frames.
// Input: pixel words in raster order over in_valid / in_ready.
// Output: one word of six sums per frame over out_valid / out_ready.
// Config: cfg_wr_en writes frame_width (index 0) or frame_height (index 1),
// clamped to 2..MAX_WIDTH and 2..4096; write only between frames.
// Throughput: one pixel per cycle while the queue has room, set by the
// single row-buffer RAM read and write per pixel and the one-word-per-cycle
// accumulator update. The last pixel of a frame passes the s1 stage and the
// queue; the sums clear for the next frame as the result register loads.
// A four-word queue sits between the pixel front end and the
// accumulators; when the receiver stalls on a result, pixels of the next
// frame keep flowing until the queue fills, then in_ready drops.
// Reset: counters, sums and sizes go to their defaults at once; the row
// buffer needs no clearing since row zero is written before it is read.
// Uses jbs_pkg, jbs_front, jbs_queue, jbs_back.
module jpeg_blockiness_statistics_top
	import jbs_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	parameter int BLOCK_SIZE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BSUM_W-1:0]    h_boundary_sum,
	output logic [BSUM_W-1:0]    v_boundary_sum,
	output logic [ASUM_W-1:0]    h_activity_sum,
	output logic [ASUM_W-1:0]    v_activity_sum,
	output logic [ZCNT_W-1:0]    h_crossing_count,
	output logic [ZCNT_W-1:0]    v_crossing_count
);

	jbs_qstat_t qstat;
	jbs_item_t  push_item, head;
	logic       push, pop;

	jbs_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.BLOCK_SIZE(BLOCK_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.pixel    (pixel),
		.qstat    (qstat),
		.push     (push),
		.push_item(push_item)
	);

	jbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.qstat    (qstat),
		.head     (head)
	);

	jbs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.qstat           (qstat),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.h_boundary_sum  (h_boundary_sum),
		.v_boundary_sum  (v_boundary_sum),
		.h_activity_sum  (h_activity_sum),
		.v_activity_sum  (v_activity_sum),
		.h_crossing_count(h_crossing_count),
		.v_crossing_count(v_crossing_count)
	);

endmodule

// ===== rtl/jbs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the blockiness statistics block, bound to the top.
// Uses jbs_pkg.
module jbs_checker
	import jbs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [BSUM_W-1:0]    h_boundary_sum,
	input logic [BSUM_W-1:0]    v_boundary_sum,
	input logic [ASUM_W-1:0]    h_activity_sum,
	input logic [ASUM_W-1:0]    v_activity_sum,
	input logic [ZCNT_W-1:0]    h_crossing_count,
	input logic [ZCNT_W-1:0]    v_crossing_count
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(h_activity_sum)
			&& $stable(h_boundary_sum) && $stable(v_activity_sum)
			&& $stable(v_boundary_sum) && $stable(h_crossing_count)
			&& $stable(v_crossing_count))
		else $error("result word changed while stalled");

	// boundary pairs are a subset of all pairs
	a_h_bnd_le_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ASUM_W'(h_boundary_sum) <= h_activity_sum)
		else $error("horizontal boundary sum above activity sum");

	// every crossing needs a nonzero difference
	a_h_zc_le_act: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ASUM_W'(h_crossing_count) <= h_activity_sum)
		else $error("horizontal crossing count above activity sum");

endmodule

bind jpeg_blockiness_statistics_top jbs_checker u_jbs_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for jpeg_blockiness_statistics_top: random grey frames,
// on-the-fly prediction of the six per-frame sums, random back-pressure.
// Depends on rtl/jbs_pkg.sv and the top-level RTL.
module tb;
	import jbs_pkg::*;

	localparam int MAX_WIDTH = 4096;
	localparam int BLOCK_SIZE = 8;
	localparam int RANDOM_ITEMS = 500;
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES = 12;
	localparam longint LIMIT_NS = 2_000_000;

	typedef struct {
		logic [BSUM_W-1:0] h_bnd;
		logic [BSUM_W-1:0] v_bnd;
		logic [ASUM_W-1:0] h_act;
		logic [ASUM_W-1:0] v_act;
		logic [ZCNT_W-1:0] h_zc;
		logic [ZCNT_W-1:0] v_zc;
	} frame_stats_t;

	class stats_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		int col;
		int row;
		logic [PIX_W-1:0] left_pix;
		logic signed [DIFF_W-1:0] left_diff;
		logic [PIX_W-1:0] above_pix [MAX_WIDTH];
		logic signed [DIFF_W-1:0] above_diff [MAX_WIDTH];
		frame_stats_t acc;
		frame_stats_t expected_stats [$];
		int pixels;
		int frames_predicted;
		int frames_checked;
		int errors;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col = 0;
			row = 0;
			left_pix = '0;
			left_diff = '0;
			acc = '{default: '0};
			pixels = 0;
			frames_predicted = 0;
			frames_checked = 0;
			errors = 0;
		endfunction

		function int clamp_size(logic [CFG_W-1:0] v, int hi);
			if (v < 2) return 2;
			if (v > hi) return hi;
			return int'(v);
		endfunction

		function int frame_pixels();
			return clamp_size(width_reg, MAX_WIDTH) * clamp_size(height_reg, 4096);
		endfunction

		function int magnitude(int d);
			return (d < 0) ? -d : d;
		endfunction

		function bit opposite(int a, int b);
			return (a < 0 && b > 0) || (a > 0 && b < 0);
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_FRAME_WIDTH)
				width_reg = val;
			else if (idx == REG_FRAME_HEIGHT)
				height_reg = val;
		endfunction

		// advance the running sums by one accepted pixel word
		function void add_pixel(logic [PIX_W-1:0] p);
			int w;
			int h;
			int dh;
			int dv;
			w = clamp_size(width_reg, MAX_WIDTH);
			h = clamp_size(height_reg, 4096);
			dh = 0;
			dv = 0;
			pixels++;
			if (col >= 1) begin
				dh = int'(p) - int'(left_pix);
				acc.h_act += magnitude(dh);
				if (col % BLOCK_SIZE == 0)
					acc.h_bnd += magnitude(dh);
				if (col >= 2 && opposite(int'(left_diff), dh))
					acc.h_zc += 1;
			end
			if (row >= 1) begin
				dv = int'(p) - int'(above_pix[col]);
				acc.v_act += magnitude(dv);
				if (row % BLOCK_SIZE == 0)
					acc.v_bnd += magnitude(dv);
				if (row >= 2 && opposite(int'(above_diff[col]), dv))
					acc.v_zc += 1;
			end
			above_pix[col] = p;
			above_diff[col] = dv[DIFF_W-1:0];
			left_pix = p;
			left_diff = dh[DIFF_W-1:0];
			if (col + 1 >= w) begin
				col = 0;
				if (row + 1 >= h) begin
					row = 0;
					expected_stats.push_back(acc);
					frames_predicted++;
					acc = '{default: '0};
				end else begin
					row++;
				end
			end else begin
				col++;
			end
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction

		task report_mismatch(string msg);
			$display("tb: mismatch at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task cmp_field(string name, longint got, longint want);
			if (got != want)
				report_mismatch($sformatf("frame %0d %s got %0d want %0d",
					frames_checked, name, got, want));
		endtask

		task check_stats(frame_stats_t got);
			frame_stats_t want;
			if (expected_stats.size() == 0) begin
				report_mismatch("result word with no frame pending");
			end else begin
				want = expected_stats.pop_front();
				cmp_field("h_boundary_sum", got.h_bnd, want.h_bnd);
				cmp_field("v_boundary_sum", got.v_bnd, want.v_bnd);
				cmp_field("h_activity_sum", got.h_act, want.h_act);
				cmp_field("v_activity_sum", got.v_act, want.v_act);
				cmp_field("h_crossing_count", got.h_zc, want.h_zc);
				cmp_field("v_crossing_count", got.v_zc, want.v_zc);
				frames_checked++;
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [PIX_W-1:0] pixel;
	logic out_valid;
	logic out_ready;
	logic [BSUM_W-1:0] h_boundary_sum;
	logic [BSUM_W-1:0] v_boundary_sum;
	logic [ASUM_W-1:0] h_activity_sum;
	logic [ASUM_W-1:0] v_activity_sum;
	logic [ZCNT_W-1:0] h_crossing_count;
	logic [ZCNT_W-1:0] v_crossing_count;

	stats_scoreboard sb;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	logic [PIX_W-1:0] last_pix = '0;

	jpeg_blockiness_statistics_top #(
		.MAX_WIDTH(MAX_WIDTH),
		.BLOCK_SIZE(BLOCK_SIZE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.h_boundary_sum(h_boundary_sum),
		.v_boundary_sum(v_boundary_sum),
		.h_activity_sum(h_activity_sum),
		.v_activity_sum(v_activity_sum),
		.h_crossing_count(h_crossing_count),
		.v_crossing_count(v_crossing_count)
	);

	always #2 clk = ~clk;

	initial begin
		#(LIMIT_NS);
		$display("[jpeg_blockiness_statistics_top] ERROR");
		$finish;
	end

	// enter and leave at a falling edge
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		if (!no_idle) begin
			while ($urandom_range(99) < 37) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!in_ready);
		sb.add_pixel(p);
		last_pix = p;
		@(negedge clk);
	endtask

	task automatic write_sizes(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_wdata <= w;
		@(negedge clk);
		sb.set_reg(REG_FRAME_WIDTH, w);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_wdata <= h;
		@(negedge clk);
		sb.set_reg(REG_FRAME_HEIGHT, h);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] next_pixel(int style, logic [PIX_W-1:0] prev);
		int v;
		case (style)
			0: v = $urandom_range(255);
			1: begin
				v = int'(prev) + $urandom_range(6) - 3;
				v = (v < 0) ? 0 : (v > 255) ? 255 : v;
			end
			2: v = $urandom_range(1) ? 255 : 0;
			default: v = prev;
		endcase
		return v[PIX_W-1:0];
	endfunction

	task automatic send_frame(input int style);
		int n;
		n = sb.frame_pixels();
		for (int i = 0; i < n; i++)
			send_pixel(next_pixel(style, last_pix));
	endtask

	task automatic run_phase(input int w, input int h, input int frames);
		write_sizes(CFG_W'(w), CFG_W'(h));
		repeat (frames) send_frame(($urandom_range(9) < 4) ? 0 : $urandom_range(3));
	endtask

	initial begin
		logic [PIX_W-1:0] dir_a [4];
		logic [PIX_W-1:0] dir_b [15];
		int phase_no;
		int kind;
		dir_a = '{8'd255, 8'd0, 8'd0, 8'd255};
		dir_b = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
			8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
			8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pixel = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sizes below the minimum clamp to 2x2; full-swing steps
		write_sizes(13'd0, 13'd1);
		foreach (dir_a[i]) send_pixel(dir_a[i]);
		// checkerboard: crossings both ways, then flat runs with zero steps
		write_sizes(13'd5, 13'd3);
		foreach (dir_b[i]) send_pixel(dir_b[i]);

		// receiver holds off while tiny frames keep coming: queue fills, input stalls
		write_sizes(13'd2, 13'd2);
		hold_req = 1'b1;
		repeat (15) send_frame(0);

		phase_no = 0;
		while (sb.pixels < RANDOM_ITEMS) begin
			no_idle = (sb.pixels >= 150 && sb.pixels < 300);
			kind = $urandom_range(5);
			case (kind)
				3: run_phase($urandom_range(24, 9), $urandom_range(4, 2), $urandom_range(1, 3));
				4: run_phase($urandom_range(4, 2), $urandom_range(18, 9), $urandom_range(1, 3));
				5: run_phase($urandom_range(17, 9), $urandom_range(11, 9), $urandom_range(1, 2));
				default: run_phase($urandom_range(5), $urandom_range(4), $urandom_range(1, 4));
			endcase
			phase_no++;
		end
		no_idle = 1'b0;

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("tb: %0d pixel words in %0d random phases, %0d frames checked, sizes 2x2 to 24x18",
			sb.pixels, phase_no, sb.frames_checked);
		$display("tb: %0d mismatches", sb.errors);
		if (sb.errors == 0) begin
			$display("[jpeg_blockiness_statistics_top] OK");
		end else begin
			$display("[jpeg_blockiness_statistics_top] ERROR");
		end
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= no_idle || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_stats('{h_boundary_sum, v_boundary_sum, h_activity_sum,
				v_activity_sum, h_crossing_count, v_crossing_count});
	end

endmodule
